// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define WPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define WPC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define WPC_ASSERT(lbl, clk, rstn, prop)
`define WPC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== hw/rtl/wpc_pkg.sv =====
// ---------------------------------------------------------------------------
// wpc_pkg
// Types and constants of the wheel pulse period counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpc_pkg;

  localparam int TS_W     = 24;
  localparam int MS_W     = 16;
  localparam int CLR_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] FUNC_PULSE = 2'd0;
  localparam logic [1:0] FUNC_PRESS = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_IVL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_CNT    = 3'd4;

  localparam logic [MS_W-1:0]  RST_MIN_PERIOD   = 16'd180;
  localparam logic [MS_W-1:0]  RST_REPORT_IVL   = 16'd500;
  localparam logic [MS_W-1:0]  RST_IDLE_TIMEOUT = 16'd10000;
  localparam logic [MS_W-1:0]  RST_DEBOUNCE     = 16'd100;
  localparam logic [CLR_W-1:0] RST_CLEAR_CNT    = 3'd5;

  localparam logic [MS_W-1:0] PERIOD_MAX = 16'hFFFF;
  localparam int TICK_MUL   = 125;
  localparam int TICK_SHIFT = 12;

  typedef enum logic [1:0] {
    OP_PULSE,
    OP_PRESS,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [TS_W-1:0] timestamp;
    logic            reed;
  } ev_t;

  typedef struct packed {
    logic [MS_W-1:0]  min_period;
    logic [MS_W-1:0]  report_ivl;
    logic [MS_W-1:0]  idle_timeout;
    logic [MS_W-1:0]  debounce;
    logic [CLR_W-1:0] clear_cnt;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wpc_queue.sv =====
// ---------------------------------------------------------------------------
// wpc_queue
// Small FIFO of classified events between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpc_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wpc_pkg::ev_t  push_data_i,
  input  logic          pop_i,
  output wpc_pkg::ev_t  pop_data_o,
  output logic          full_o,
  output logic          empty_o
);
  import wpc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ev_t           mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wpc_front.sv =====
// ---------------------------------------------------------------------------
// wpc_front
// Input side: takes events, decodes the event kind, drops unused kinds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpc_front (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_func_i,
  input  logic [wpc_pkg::TS_W-1:0]  in_timestamp_i,
  input  logic                      in_reed_closed_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output wpc_pkg::ev_t              q_data_o
);
  import wpc_pkg::*;

  logic keep;

  always_comb begin
    keep        = 1'b1;
    q_data_o.op = OP_PULSE;
    case (in_func_i)
      FUNC_PULSE: q_data_o.op = OP_PULSE;
      FUNC_PRESS: q_data_o.op = OP_PRESS;
      FUNC_TICK:  q_data_o.op = OP_TICK;
      default:    keep = 1'b0;
    endcase
    q_data_o.timestamp = in_timestamp_i;
    q_data_o.reed      = in_reed_closed_i;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/wpc_back.sv =====
// ---------------------------------------------------------------------------
// wpc_back
// Execution side: elapsed times, counters, report decisions, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wpc_back #(
  parameter int TIME_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wpc_pkg::cfg_t             cfg_i,
  input  logic                      ev_avail_i,
  input  wpc_pkg::ev_t              ev_i,
  output logic                      ev_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [wpc_pkg::TS_W-1:0]  out_revolutions_o,
  output logic [wpc_pkg::MS_W-1:0]  out_period_ms_o,
  output logic                      out_is_timeout_o
);
  import wpc_pkg::*;

  localparam int PROD_W = TIME_BITS + 7;
  localparam int EMS_W  = PROD_W - TICK_SHIFT;
  localparam int CMP_W  = (EMS_W > MS_W) ? EMS_W : MS_W;

  function automatic logic [CMP_W-1:0] elapsed_ms(input logic [TIME_BITS-1:0] now,
                                                  input logic [TIME_BITS-1:0] then_t);
    logic [TIME_BITS-1:0] ticks;
    logic [PROD_W-1:0]    prod;
    ticks = now - then_t;
    prod  = PROD_W'(ticks) * PROD_W'(TICK_MUL);
    return CMP_W'(prod[PROD_W-1:TICK_SHIFT]);
  endfunction

  logic [TIME_BITS-1:0] last_pulse_q, last_pulse_d;
  logic [TIME_BITS-1:0] last_report_q, last_report_d;
  logic [TIME_BITS-1:0] last_press_q, last_press_d;
  logic [TS_W-1:0]      revs_q, revs_d;
  logic [CLR_W-1:0]     run_q, run_d;
  logic                 armed_q, armed_d;
  logic                 out_valid_q, out_valid_d;
  logic [TS_W-1:0]      out_revs_q, out_revs_d;
  logic [MS_W-1:0]      out_period_q, out_period_d;
  logic                 out_tmo_q, out_tmo_d;

  logic [TIME_BITS-1:0] now;
  logic [CMP_W-1:0]     pulse_ms, report_ms, press_ms;
  logic [CLR_W-1:0]     run_inc;
  logic                 fire;

  assign now       = TIME_BITS'({{(32 - TS_W){1'b0}}, ev_i.timestamp});
  assign pulse_ms  = elapsed_ms(now, last_pulse_q);
  assign report_ms = elapsed_ms(now, last_report_q);
  assign press_ms  = elapsed_ms(now, last_press_q);
  assign run_inc   = run_q + CLR_W'(1);
  assign ev_pop_o  = ev_avail_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    last_pulse_d  = last_pulse_q;
    last_report_d = last_report_q;
    last_press_d  = last_press_q;
    revs_d        = revs_q;
    run_d         = run_q;
    armed_d       = armed_q;
    fire          = 1'b0;
    out_revs_d    = out_revs_q;
    out_period_d  = out_period_q;
    out_tmo_d     = out_tmo_q;
    if (ev_pop_o) begin
      case (ev_i.op)
        OP_PULSE: begin
          if (pulse_ms >= CMP_W'(cfg_i.min_period)) begin
            last_pulse_d = now;
            revs_d       = revs_q + TS_W'(1);
            if (report_ms >= CMP_W'(cfg_i.report_ivl)) begin
              last_report_d = now;
              armed_d       = 1'b1;
              fire          = 1'b1;
              out_revs_d    = revs_q + TS_W'(1);
              out_period_d  = (pulse_ms > CMP_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                              : pulse_ms[MS_W-1:0];
              out_tmo_d     = 1'b0;
            end
          end
        end
        OP_PRESS: begin
          if (press_ms >= CMP_W'(cfg_i.debounce)) begin
            last_press_d = now;
            if (ev_i.reed) begin
              run_d = run_inc;
              if (run_inc >= cfg_i.clear_cnt) begin
                revs_d = '0;
                run_d  = '0;
              end
            end else begin
              run_d = '0;
            end
          end
        end
        OP_TICK: begin
          if (armed_q && (report_ms >= CMP_W'(cfg_i.idle_timeout))) begin
            armed_d      = 1'b0;
            fire         = 1'b1;
            out_revs_d   = revs_q;
            out_period_d = '0;
            out_tmo_d    = 1'b1;
          end
        end
        default: ;
      endcase
    end
    out_valid_d = ev_pop_o ? fire : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pulse_q  <= '0;
      last_report_q <= '0;
      last_press_q  <= '0;
      revs_q        <= '0;
      run_q         <= '0;
      armed_q       <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      last_pulse_q  <= last_pulse_d;
      last_report_q <= last_report_d;
      last_press_q  <= last_press_d;
      revs_q        <= revs_d;
      run_q         <= run_d;
      armed_q       <= armed_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_revs_q   <= out_revs_d;
    out_period_q <= out_period_d;
    out_tmo_q    <= out_tmo_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_revolutions_o = out_revs_q;
  assign out_period_ms_o   = out_period_q;
  assign out_is_timeout_o  = out_tmo_q;

  `WPC_ASSERT(a_tmo_period_zero, clk_i, rst_ni, (out_valid_q && out_tmo_q) |-> (out_period_q == '0))
  `WPC_ASSERT(a_tick_fire_disarms, clk_i, rst_ni, (ev_pop_o && (ev_i.op == OP_TICK) && fire) |=> !armed_q)
  `WPC_ASSERT_NEVER(a_tick_fire_unarmed, clk_i, rst_ni, ev_pop_o && (ev_i.op == OP_TICK) && fire && !armed_q)
  `WPC_ASSERT(a_pulse_fire_arms, clk_i, rst_ni, (ev_pop_o && (ev_i.op == OP_PULSE) && fire) |=> (armed_q && out_valid_q && !out_tmo_q))

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_pulse_period_counter.sv =====
// ---------------------------------------------------------------------------
// wheel_pulse_period_counter
// Pulse-period tachometer with debounced clear button, on timestamped events.
// ---------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i/in_stall_o, func, timestamp,   | in
//          | reed_closed                               |
//  out     | out_valid_o/out_stall_i, revolutions,     | out
//          | period_ms, is_timeout                     |
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
//  One event per cycle sustained while the output is not stalled; the back end
//  decides each event combinationally (wrapped subtract, multiply by 125,
//  compare) and registers the result on the edge that takes the event out of
//  the queue, so a result is held first in the queue, then in the output register.
//  Reset is asynchronous, active low, and loads the register defaults.
//  The queue of QUEUE_DEPTH events lets input transfers continue while a result
//  waits; in_stall_o rises only when the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wheel_pulse_period_counter #(
  parameter int TIME_BITS   = 24,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_func_i,
  input  logic [wpc_pkg::TS_W-1:0]      in_timestamp_i,
  input  logic                          in_reed_closed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wpc_pkg::TS_W-1:0]      out_revolutions_o,
  output logic [wpc_pkg::MS_W-1:0]      out_period_ms_o,
  output logic                          out_is_timeout_o,
  input  logic                          cfg_we_i,
  input  logic [wpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wpc_pkg::MS_W-1:0]      cfg_data_i
);
  import wpc_pkg::*;

  cfg_t cfg_q, cfg_d;
  ev_t  push_data, pop_data;
  logic push, pop, q_full, q_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_PERIOD:   cfg_d.min_period   = cfg_data_i;
        REG_REPORT_IVL:   cfg_d.report_ivl   = cfg_data_i;
        REG_IDLE_TIMEOUT: cfg_d.idle_timeout = cfg_data_i;
        REG_DEBOUNCE:     cfg_d.debounce     = cfg_data_i;
        REG_CLEAR_CNT:    cfg_d.clear_cnt    = cfg_data_i[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_period   <= RST_MIN_PERIOD;
      cfg_q.report_ivl   <= RST_REPORT_IVL;
      cfg_q.idle_timeout <= RST_IDLE_TIMEOUT;
      cfg_q.debounce     <= RST_DEBOUNCE;
      cfg_q.clear_cnt    <= RST_CLEAR_CNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wpc_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_func_i        (in_func_i),
    .in_timestamp_i   (in_timestamp_i),
    .in_reed_closed_i (in_reed_closed_i),
    .q_full_i         (q_full),
    .q_push_o         (push),
    .q_data_o         (push_data)
  );

  wpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  wpc_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .ev_avail_i        (!q_empty),
    .ev_i              (pop_data),
    .ev_pop_o          (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_revolutions_o (out_revolutions_o),
    .out_period_ms_o   (out_period_ms_o),
    .out_is_timeout_o  (out_is_timeout_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_wheel_pulse_period_counter.sv =====
// ---------------------------------------------------------------------------
// tb_wheel_pulse_period_counter
// Self-checking bench: a directed event table, then random event streams under
// several register settings; every output transfer is compared with the expectation
// typed in the table or, for untyped events, with a tachometer model kept in the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wheel_pulse_period_counter;
  import wpc_pkg::*;

  localparam logic [1:0]           FUNC_NONE        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam int N_DIR        = 21;
  localparam int N_PHASE      = 6;
  localparam int PHASE_EVENTS = 225;
  localparam int HOLD_CYC     = 200;
  localparam int SETTLE_CYC   = 8;
  localparam int WD_LIMIT     = 5000;

  typedef struct packed {
    logic [TS_W-1:0] rev;
    logic [MS_W-1:0] per;
    logic            is_to;
  } report_t;

  localparam report_t NO_REP = '0;

  typedef struct packed {
    logic [1:0]      func;
    logic [TS_W-1:0] ts;
    logic            reed;
    logic            typed;
    logic            has_rep;
    report_t         rep;
  } dir_row_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func   = FUNC_PULSE;
  logic [TS_W-1:0]      in_ts     = '0;
  logic                 in_reed   = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TS_W-1:0]      out_rev;
  logic [MS_W-1:0]      out_per;
  logic                 out_to;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_MIN_PERIOD;
  logic [MS_W-1:0]      cfg_data  = '0;

  // typed expectation travelling with the event on the input channel
  logic    cur_typed = 1'b0;
  logic    cur_has   = 1'b0;
  report_t cur_rep   = NO_REP;

  // tachometer model state and registers
  logic [MS_W-1:0]  c_min   = RST_MIN_PERIOD;
  logic [MS_W-1:0]  c_rep   = RST_REPORT_IVL;
  logic [MS_W-1:0]  c_to    = RST_IDLE_TIMEOUT;
  logic [MS_W-1:0]  c_deb   = RST_DEBOUNCE;
  logic [CLR_W-1:0] c_clr   = RST_CLEAR_CNT;
  logic [31:0]      rev_cnt = '0;
  logic [TS_W-1:0]  t_pulse = '0;
  logic [TS_W-1:0]  t_rep   = '0;
  logic [TS_W-1:0]  t_press = '0;
  logic [2:0]       run     = '0;
  logic             armed   = 1'b1;

  report_t         report_q[$];
  dir_row_t        dir_tab[N_DIR];
  logic [TS_W-1:0] ev_clock = '0;

  int errors = 0, n_in = 0, n_rep = 0, n_idle_rep = 0, n_clear = 0, idle_cyc = 0;
  bit idle_on = 1'b1, hold_req = 1'b0;

  wheel_pulse_period_counter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_func_i        (in_func),
    .in_timestamp_i   (in_ts),
    .in_reed_closed_i (in_reed),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_revolutions_o(out_rev),
    .out_period_ms_o  (out_per),
    .out_is_timeout_o (out_to),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [31:0] span_ms(logic [TS_W-1:0] now, logic [TS_W-1:0] then);
    logic [TS_W-1:0] d;
    d = now - then;
    return ({8'd0, d} * TICK_MUL) >> TICK_SHIFT;
  endfunction

  function automatic logic [TS_W-1:0] ms_ticks(int unsigned ms);
    return TS_W'((ms * 4096) / 125);
  endfunction

  function automatic logic [TS_W-1:0] rand_gap(int unsigned scale_ms);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return TS_W'($urandom_range(0, 63));
    if (r < 50) return ms_ticks($urandom_range(0, 2 * scale_ms + 50));
    if (r < 78) return ms_ticks($urandom_range(0, 2 * c_rep + 50));
    if (r < 93) return ms_ticks($urandom_range(0, c_to + c_to / 4 + 50));
    return TS_W'($urandom());
  endfunction

  task automatic tach_predict(input logic [1:0] f, input logic [TS_W-1:0] now,
                              input logic rd, output logic has, output report_t r);
    logic [31:0] per;
    has = 1'b0;
    r   = NO_REP;
    case (f)
      FUNC_PULSE: begin
        per = span_ms(now, t_pulse);
        if (per >= c_min) begin
          t_pulse = now;
          rev_cnt = rev_cnt + 32'd1;
          if (span_ms(now, t_rep) >= c_rep) begin
            t_rep   = now;
            armed   = 1'b1;
            has     = 1'b1;
            r.rev   = rev_cnt[TS_W-1:0];
            r.per   = (per > PERIOD_MAX) ? PERIOD_MAX : per[MS_W-1:0];
            r.is_to = 1'b0;
          end
        end
      end
      FUNC_PRESS: begin
        if (span_ms(now, t_press) >= c_deb) begin
          t_press = now;
          if (rd) begin
            run = run + 3'd1;
            if (run >= c_clr) begin
              rev_cnt = '0;
              run     = '0;
              n_clear++;
            end
          end else begin
            run = '0;
          end
        end
      end
      FUNC_TICK: begin
        if (armed && span_ms(now, t_rep) >= c_to) begin
          armed   = 1'b0;
          has     = 1'b1;
          r.rev   = rev_cnt[TS_W-1:0];
          r.per   = '0;
          r.is_to = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : mon_in
    logic    has;
    report_t r;
    if (rst_ni && in_valid && !in_stall) begin
      tach_predict(in_func, in_ts, in_reed, has, r);
      n_in++;
      if (cur_typed) begin
        has = cur_has;
        r   = cur_rep;
      end
      if (has) report_q.push_back(r);
    end
  end

  always @(posedge clk_i) begin : mon_out
    report_t want, got;
    if (rst_ni && out_valid && !out_stall) begin
      got = {out_rev, out_per, out_to};
      n_rep++;
      if (out_to) n_idle_rep++;
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected report: rev=%0d per=%0d idle=%0b", got.rev, got.per, got.is_to);
      end else begin
        want = report_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("report mismatch: exp rev=%0d per=%0d idle=%0b, got rev=%0d per=%0d idle=%0b",
                     want.rev, want.per, want.is_to, got.rev, got.per, got.is_to);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports pending",
               WD_LIMIT, report_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : rx
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic send_ev(input logic [1:0] f, input logic [TS_W-1:0] ts, input logic rd,
                         input logic typed, input logic has, input report_t r);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_ts     <= ts;
    in_reed   <= rd;
    cur_typed <= typed;
    cur_has   <= has;
    cur_rep   <= r;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      REG_MIN_PERIOD:   c_min = val;
      REG_REPORT_IVL:   c_rep = val;
      REG_IDLE_TIMEOUT: c_to  = val;
      REG_DEBOUNCE:     c_deb = val;
      REG_CLEAR_CNT:    c_clr = val[CLR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [MS_W-1:0] mn, input logic [MS_W-1:0] rp,
                          input logic [MS_W-1:0] to, input logic [MS_W-1:0] db,
                          input logic [CLR_W-1:0] cl);
    logic [MS_W-1:0] rnd;
    rnd = MS_W'($urandom());
    write_reg(REG_MIN_PERIOD, mn);
    write_reg(REG_REPORT_IVL, rp);
    write_reg(REG_IDLE_TIMEOUT, to);
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_CLEAR_CNT, {rnd[MS_W-1:CLR_W], cl});
    write_reg(CFG_IDX_W'(REG_FIRST_UNUSED + $urandom_range(0, 2)), MS_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n_events);
    int          sent, k, n_press;
    int unsigned r;
    logic [1:0]  f;
    logic        rd;
    sent = 0;
    while (sent < n_events) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // clean run of closed-reed presses spaced past the debounce time
        n_press = (c_clr == 0) ? 1 : c_clr;
        for (k = 0; k < n_press; k++) begin
          ev_clock = ev_clock + ms_ticks(c_deb + $urandom_range(1, 40));
          send_ev(FUNC_PRESS, ev_clock, 1'b1, 1'b0, 1'b0, NO_REP);
        end
        sent += n_press;
      end else if (r < 9) begin
        send_ev(FUNC_NONE, TS_W'($urandom()), 1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_REP);
        sent++;
      end else begin
        r  = $urandom_range(0, 99);
        rd = ($urandom_range(0, 99) < 85);
        if (r < 45) begin
          f = FUNC_PULSE;
          ev_clock = ev_clock + rand_gap(c_min);
        end else if (r < 68) begin
          f = FUNC_PRESS;
          ev_clock = ev_clock + rand_gap(c_deb);
        end else begin
          f = FUNC_TICK;
          ev_clock = ev_clock + rand_gap(c_to / 2);
        end
        send_ev(f, ev_clock, rd, 1'b0, 1'b0, NO_REP);
        sent++;
      end
    end
  endtask

  initial begin : stim
    int i, p;
    // 1000 ms = 32768 ticks; reset settings apply to the whole table
    dir_tab = '{
      '{FUNC_TICK,  24'd0,      1'b0, 1'b1, 1'b0, NO_REP},
      '{FUNC_PULSE, 24'd0,      1'b0, 1'b1, 1'b0, NO_REP},
      '{FUNC_PULSE, 24'd16384,  1'b0, 1'b1, 1'b1, '{24'd1, 16'd500, 1'b0}},
      '{FUNC_PULSE, 24'd20480,  1'b0, 1'b1, 1'b0, NO_REP},
      '{FUNC_PULSE, 24'd24576,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PULSE, 24'd57344,  1'b0, 1'b1, 1'b1, '{24'd3, 16'd1000, 1'b0}},
      '{FUNC_NONE,  24'hFFFFFF, 1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_TICK,  24'd385024, 1'b0, 1'b1, 1'b1, '{24'd3, 16'd0, 1'b1}},
      '{FUNC_TICK,  24'd417792, 1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PULSE, 24'hFFFFFF, 1'b0, 1'b1, 1'b1, '{24'd4, 16'hFFFF, 1'b0}},
      '{FUNC_PULSE, 24'd16383,  1'b0, 1'b1, 1'b1, '{24'd5, 16'd500, 1'b0}},
      '{FUNC_PRESS, 24'd20480,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd21504,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd24576,  1'b0, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd28672,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd32768,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd36864,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd40960,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PRESS, 24'd45056,  1'b1, 1'b1, 1'b0, NO_REP},
      '{FUNC_PULSE, 24'd77824,  1'b0, 1'b0, 1'b0, NO_REP},
      '{FUNC_TICK,  24'd110592, 1'b1, 1'b0, 1'b0, NO_REP}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < N_DIR; i++)
      send_ev(dir_tab[i].func, dir_tab[i].ts, dir_tab[i].reed,
              dir_tab[i].typed, dir_tab[i].has_rep, dir_tab[i].rep);
    ev_clock = dir_tab[N_DIR-1].ts;
    drain();

    for (p = 0; p < N_PHASE; p++) begin
      case (p)
        0: set_regs('0, '0, '0, '0, '0);
        1: set_regs('1, '1, '1, '1, '1);
        2: set_regs(RST_MIN_PERIOD, RST_REPORT_IVL, RST_IDLE_TIMEOUT, RST_DEBOUNCE,
                    RST_CLEAR_CNT);
        default: set_regs(MS_W'($urandom_range(0, 400)), MS_W'($urandom_range(0, 1500)),
                          MS_W'($urandom_range(0, 15000)), MS_W'($urandom_range(0, 300)),
                          CLR_W'($urandom_range(0, 7)));
      endcase
      if (p == 0) hold_req = 1'b1;
      if (p == N_PHASE - 1) idle_on = 1'b0;
      run_random(PHASE_EVENTS);
      drain();
    end

    $display("run covered %0d events over %0d register settings and %0d count clears",
             n_in, N_PHASE + 1, n_clear);
    $display("%0d reports checked (%0d idle timeouts), %0d mismatches",
             n_rep, n_idle_rep, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wpc_pkg.sv
hw/rtl/wpc_queue.sv
hw/rtl/wpc_front.sv
hw/rtl/wpc_back.sv
hw/rtl/wheel_pulse_period_counter.sv
tb/sv/tb_wheel_pulse_period_counter.sv
